// ===== rtl/mkced_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-key click event detector package
// Shared types and constants for the key lanes, the event merge stage and
// the top level.
// ----------------------------------------------------------------------------
package mkced_pkg;

  // Per-key state machine encoding.
  typedef enum logic [2:0] {
    ST_RELEASED    = 3'd0,
    ST_PRESS_DB    = 3'd1,
    ST_PRESSED     = 3'd2,
    ST_RELEASE_DB  = 3'd3,
    ST_WAIT_DOUBLE = 3'd4,
    ST_WAIT_TRIPLE = 3'd5,
    ST_LONG        = 3'd6
  } key_state_e;

  // Event codes as seen on the result channel.
  typedef enum logic [2:0] {
    EV_SINGLE   = 3'd0,
    EV_DOUBLE   = 3'd1,
    EV_TRIPLE   = 3'd2,
    EV_LONG     = 3'd3,
    EV_REPEAT   = 3'd4,
    EV_LONG_REL = 3'd5
  } key_event_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE    = 3'd0,
    REG_MULTI_CLICK = 3'd1,
    REG_LONG_PRESS  = 3'd2,
    REG_REPEAT      = 3'd3,
    REG_POLARITY    = 3'd4
  } cfg_reg_e;

  localparam int unsigned TICKS_W   = 16;
  localparam int unsigned LEVELS_W  = 4;
  localparam int unsigned KEY_IDX_W = 2;

  // Register values after reset.
  localparam logic [TICKS_W-1:0] RST_DEBOUNCE    = 16'd20;
  localparam logic [TICKS_W-1:0] RST_MULTI_CLICK = 16'd300;
  localparam logic [TICKS_W-1:0] RST_LONG_PRESS  = 16'd1000;
  localparam logic [TICKS_W-1:0] RST_REPEAT      = 16'd200;
  localparam logic               RST_POLARITY    = 1'b0;

  // Release that completes this many clicks reports a triple click.
  localparam logic [1:0] CLICK_LIMIT = 2'd3;

  // Events kept per tick; later ones in lane order are dropped.
  localparam int unsigned MAX_EVENTS = 8;

  typedef struct packed {
    logic [TICKS_W-1:0] debounce_ticks;
    logic [TICKS_W-1:0] multi_click_ticks;
    logic [TICKS_W-1:0] long_press_ticks;
    logic [TICKS_W-1:0] repeat_ticks;
    logic               press_polarity;
  } cfg_t;

  // Up to two events a lane can raise in one tick, in emission order.
  typedef struct packed {
    logic       valid0;
    key_event_e code0;
    logic       valid1;
    key_event_e code1;
  } lane_ev_t;

endpackage

// ===== rtl/mkced_lane.sv =====
// ----------------------------------------------------------------------------
// Key lane
// Debounce, click counting and long press timing for a single key. All four
// timers and the state machine advance once per accepted tick.
// ----------------------------------------------------------------------------
module mkced_lane #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tick_i,
  input  logic              level_i,
  input  mkced_pkg::cfg_t   cfg_i,
  output mkced_pkg::lane_ev_t ev_o
);

  localparam int unsigned WB = (TIMER_BITS > mkced_pkg::TICKS_W) ? TIMER_BITS
                                                                 : mkced_pkg::TICKS_W;
  localparam logic [WB-1:0] TMAX = WB'({TIMER_BITS{1'b1}});

  mkced_pkg::key_state_e fsm_q, fsm_d;
  mkced_pkg::key_event_e last_q, last_d;
  logic                  pin_q, pin_d;
  logic [1:0]            cnt_q, cnt_d;
  logic [TIMER_BITS-1:0] deb_q, deb_d, mc_q, mc_d, lp_q, lp_d, rep_q, rep_d;

  logic [TIMER_BITS-1:0] deb_ld, mc_ld, lp_ld, rep_ld;
  logic                  fire_rep, fire_deb, fire_lp, fire_mc;
  mkced_pkg::key_event_e code_deb, code_mc;

  // Timer loads saturate when the timer is narrower than the register.
  function automatic logic [TIMER_BITS-1:0] sat_load(input logic [mkced_pkg::TICKS_W-1:0] v);
    logic [WB-1:0] ext;
    ext = WB'(v);
    if (ext > TMAX) ext = TMAX;
    return ext[TIMER_BITS-1:0];
  endfunction

  assign deb_ld = sat_load(cfg_i.debounce_ticks);
  assign mc_ld  = sat_load(cfg_i.multi_click_ticks);
  assign lp_ld  = sat_load(cfg_i.long_press_ticks);
  assign rep_ld = sat_load(cfg_i.repeat_ticks);

  // Next state: edge handling, timer countdown, then expiry handlers in the
  // order repeat, debounce, long press, multi-click.
  always_comb begin
    logic                  pressed;
    logic                  exp_rep, exp_deb, exp_lp, exp_mc;
    logic [TIMER_BITS-1:0] deb_pre;
    logic [1:0]            n;
    pressed  = (level_i == cfg_i.press_polarity);
    fsm_d    = fsm_q;
    pin_d    = pin_q;
    cnt_d    = cnt_q;
    last_d   = last_q;
    deb_pre  = deb_q;
    fire_rep = 1'b0;
    fire_deb = 1'b0;
    fire_lp  = 1'b0;
    fire_mc  = 1'b0;
    code_deb = mkced_pkg::EV_LONG_REL;
    code_mc  = mkced_pkg::EV_SINGLE;
    n        = cnt_q + 2'd1;

    if (level_i != pin_q) begin
      pin_d = level_i;
      if (pressed) begin
        if (fsm_q == mkced_pkg::ST_RELEASED || fsm_q == mkced_pkg::ST_WAIT_DOUBLE ||
            fsm_q == mkced_pkg::ST_WAIT_TRIPLE || fsm_q == mkced_pkg::ST_LONG) begin
          fsm_d   = mkced_pkg::ST_PRESS_DB;
          deb_pre = deb_ld;
        end
      end else if (fsm_q == mkced_pkg::ST_PRESSED || fsm_q == mkced_pkg::ST_LONG) begin
        fsm_d   = mkced_pkg::ST_RELEASE_DB;
        deb_pre = deb_ld;
      end
    end

    exp_rep = (rep_q == TIMER_BITS'(1));
    exp_deb = (deb_pre == TIMER_BITS'(1));
    exp_lp  = (lp_q == TIMER_BITS'(1));
    exp_mc  = (mc_q == TIMER_BITS'(1));
    rep_d   = (rep_q != '0) ? rep_q - TIMER_BITS'(1) : rep_q;
    deb_d   = (deb_pre != '0) ? deb_pre - TIMER_BITS'(1) : deb_pre;
    lp_d    = (lp_q != '0) ? lp_q - TIMER_BITS'(1) : lp_q;
    mc_d    = (mc_q != '0) ? mc_q - TIMER_BITS'(1) : mc_q;

    if (exp_rep) begin
      fire_rep = 1'b1;
      last_d   = mkced_pkg::EV_REPEAT;
      rep_d    = rep_ld;
    end

    if (exp_deb) begin
      case (fsm_d)
        mkced_pkg::ST_PRESS_DB: begin
          if (pressed) begin
            fsm_d  = mkced_pkg::ST_PRESSED;
            lp_d   = lp_ld;
            exp_lp = 1'b0;
          end else begin
            fsm_d = mkced_pkg::ST_RELEASED;
          end
        end
        mkced_pkg::ST_RELEASE_DB: begin
          if (pressed) begin
            fsm_d = mkced_pkg::ST_PRESSED;
          end else if (last_d == mkced_pkg::EV_LONG || last_d == mkced_pkg::EV_REPEAT) begin
            fsm_d    = mkced_pkg::ST_RELEASED;
            fire_deb = 1'b1;
            code_deb = mkced_pkg::EV_LONG_REL;
            last_d   = mkced_pkg::EV_LONG_REL;
            rep_d    = '0;
          end else if (n == mkced_pkg::CLICK_LIMIT) begin
            fsm_d    = mkced_pkg::ST_RELEASED;
            cnt_d    = 2'd0;
            fire_deb = 1'b1;
            code_deb = mkced_pkg::EV_TRIPLE;
            last_d   = mkced_pkg::EV_TRIPLE;
          end else begin
            cnt_d  = n;
            fsm_d  = (n == 2'd1) ? mkced_pkg::ST_WAIT_DOUBLE : mkced_pkg::ST_WAIT_TRIPLE;
            mc_d   = mc_ld;
            exp_mc = 1'b0;
          end
        end
        mkced_pkg::ST_LONG: begin
          if (!pressed) begin
            fsm_d    = mkced_pkg::ST_RELEASED;
            fire_deb = 1'b1;
            code_deb = mkced_pkg::EV_LONG_REL;
            last_d   = mkced_pkg::EV_LONG_REL;
          end
        end
        default: begin
        end
      endcase
    end

    if (exp_lp && fsm_d == mkced_pkg::ST_PRESSED) begin
      fsm_d   = mkced_pkg::ST_LONG;
      fire_lp = 1'b1;
      last_d  = mkced_pkg::EV_LONG;
      rep_d   = rep_ld;
    end

    if (exp_mc) begin
      if (fsm_d == mkced_pkg::ST_WAIT_DOUBLE) begin
        fsm_d   = mkced_pkg::ST_RELEASED;
        cnt_d   = 2'd0;
        fire_mc = 1'b1;
        code_mc = mkced_pkg::EV_SINGLE;
        last_d  = mkced_pkg::EV_SINGLE;
      end else if (fsm_d == mkced_pkg::ST_WAIT_TRIPLE) begin
        fsm_d   = mkced_pkg::ST_RELEASED;
        cnt_d   = 2'd0;
        fire_mc = 1'b1;
        code_mc = mkced_pkg::EV_DOUBLE;
        last_d  = mkced_pkg::EV_DOUBLE;
      end
    end
  end

  // Outputs: pack the raised events, in handler order, into two slots.
  always_comb begin
    logic                  fl [4];
    mkced_pkg::key_event_e cd [4];
    logic                  got0;
    fl[0] = fire_rep;  cd[0] = mkced_pkg::EV_REPEAT;
    fl[1] = fire_deb;  cd[1] = code_deb;
    fl[2] = fire_lp;   cd[2] = mkced_pkg::EV_LONG;
    fl[3] = fire_mc;   cd[3] = code_mc;
    got0  = 1'b0;
    ev_o  = '0;
    for (int i = 0; i < 4; i++) begin
      if (fl[i]) begin
        if (!got0) begin
          ev_o.valid0 = 1'b1;
          ev_o.code0  = cd[i];
          got0        = 1'b1;
        end else begin
          ev_o.valid1 = 1'b1;
          ev_o.code1  = cd[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q  <= mkced_pkg::ST_RELEASED;
      last_q <= mkced_pkg::EV_SINGLE;
      pin_q  <= ~mkced_pkg::RST_POLARITY;
      cnt_q  <= 2'd0;
      deb_q  <= '0;
      mc_q   <= '0;
      lp_q   <= '0;
      rep_q  <= '0;
    end else if (tick_i) begin
      fsm_q  <= fsm_d;
      last_q <= last_d;
      pin_q  <= pin_d;
      cnt_q  <= cnt_d;
      deb_q  <= deb_d;
      mc_q   <= mc_d;
      lp_q   <= lp_d;
      rep_q  <= rep_d;
    end
  end

endmodule

// ===== rtl/mkced_merge.sv =====
// ----------------------------------------------------------------------------
// Event merge stage
// Captures the events of one tick from all lanes and hands them out one per
// cycle while out_stall_i is low, in lane order, lowest slot first.
// ----------------------------------------------------------------------------
module mkced_merge #(
  parameter int unsigned NUM_KEYS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  mkced_pkg::lane_ev_t                 lane_ev_i [NUM_KEYS],
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic [mkced_pkg::KEY_IDX_W-1:0]     key_index_o,
  output mkced_pkg::key_event_e               key_event_o,
  output logic                                last_o,
  output logic                                busy_stall_o
);

  localparam int unsigned NS  = 2 * NUM_KEYS;
  localparam int unsigned CNT_W = $clog2(mkced_pkg::MAX_EVENTS + 1);

  logic [NS-1:0]         mask_q, mask_d, mask_rest;
  mkced_pkg::key_event_e code_q [NS];
  mkced_pkg::key_event_e code_d [NS];
  logic                  out_fire;

  assign mask_rest    = mask_q & (mask_q - NS'(1));
  assign out_valid_o  = |mask_q;
  assign last_o       = (mask_rest == '0);
  assign out_fire     = out_valid_o && !out_stall_i;
  // Busy until the final event of the held tick leaves.
  assign busy_stall_o = out_valid_o && !(last_o && !out_stall_i);

  // Lowest pending slot drives the result.
  always_comb begin
    key_index_o = '0;
    key_event_o = code_q[0];
    for (int j = NS - 1; j >= 0; j--) begin
      if (mask_q[j]) begin
        key_index_o = mkced_pkg::KEY_IDX_W'(j >> 1);
        key_event_o = code_q[j];
      end
    end
  end

  always_comb begin
    logic [CNT_W-1:0] cnt;
    cnt    = '0;
    mask_d = mask_q;
    code_d = code_q;
    if (load_i) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        mask_d[2*k]   = lane_ev_i[k].valid0 && (cnt < CNT_W'(mkced_pkg::MAX_EVENTS));
        cnt           = cnt + CNT_W'(mask_d[2*k]);
        mask_d[2*k+1] = lane_ev_i[k].valid1 && (cnt < CNT_W'(mkced_pkg::MAX_EVENTS));
        cnt           = cnt + CNT_W'(mask_d[2*k+1]);
        code_d[2*k]   = lane_ev_i[k].code0;
        code_d[2*k+1] = lane_ev_i[k].code1;
      end
    end else if (out_fire) begin
      mask_d = mask_rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

endmodule

// ===== rtl/multi_key_click_event_detector_core.sv =====
// ----------------------------------------------------------------------------
// Multi-key click event detector core
// One lane per key detects single, double and triple clicks, long press,
// long repeat and long release; a merge stage serializes the events.
// ----------------------------------------------------------------------------
// Usage:
// Each input request carries one tick: the raw level of every key. It is
// accepted on a rising edge with in_valid_i high and in_stall_o low. Every
// lane updates its debounce, click and long press state in that same cycle.
// The events of the tick appear on the result channel starting the next
// cycle, one per cycle, ordered by key index and within a key by handler
// order; last_o marks the final event of the tick. A tick with no events
// produces nothing.
// Throughput: one tick per cycle while each tick yields at most one event.
// A tick with more than one event holds the result register until each is
// taken, and the input is stalled until its final event is taken; that
// single output register is what limits the rate. When the receiver raises
// out_stall_i, the shown event holds and further ticks wait.
// Configuration writes (cfg_valid_i, always ready) take effect at once and
// should be made while no tick is in flight. Reset restores all register
// defaults, sets every lane to released and clears all timers.
// ----------------------------------------------------------------------------
module multi_key_click_event_detector_core #(
  parameter int unsigned NUM_KEYS   = 4,
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Tick requests.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [mkced_pkg::LEVELS_W-1:0]      key_levels_i,
  // Event results.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [mkced_pkg::KEY_IDX_W-1:0]     key_index_o,
  output logic [2:0]                          key_event_o,
  output logic                                last_o,
  // Configuration writes.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mkced_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mkced_pkg::TICKS_W-1:0]       cfg_data_i
);

  mkced_pkg::cfg_t       cfg_q, cfg_d;
  mkced_pkg::lane_ev_t   lane_ev [NUM_KEYS];
  mkced_pkg::key_event_e evt;
  logic                  tick;

  // Registers are always writable; writes to unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        mkced_pkg::REG_DEBOUNCE:    cfg_d.debounce_ticks    = cfg_data_i;
        mkced_pkg::REG_MULTI_CLICK: cfg_d.multi_click_ticks = cfg_data_i;
        mkced_pkg::REG_LONG_PRESS:  cfg_d.long_press_ticks  = cfg_data_i;
        mkced_pkg::REG_REPEAT:      cfg_d.repeat_ticks      = cfg_data_i;
        mkced_pkg::REG_POLARITY:    cfg_d.press_polarity    = cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks    <= mkced_pkg::RST_DEBOUNCE;
      cfg_q.multi_click_ticks <= mkced_pkg::RST_MULTI_CLICK;
      cfg_q.long_press_ticks  <= mkced_pkg::RST_LONG_PRESS;
      cfg_q.repeat_ticks      <= mkced_pkg::RST_REPEAT;
      cfg_q.press_polarity    <= mkced_pkg::RST_POLARITY;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // A tick is taken whenever the merge stage can hold its events.
  assign tick = in_valid_i && !in_stall_o;

  // Keys beyond the input width see a constant low level.
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic level;
    if (k < mkced_pkg::LEVELS_W) begin : g_pin
      assign level = key_levels_i[k];
    end else begin : g_tie
      assign level = 1'b0;
    end

    mkced_lane #(
      .TIMER_BITS(TIMER_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tick_i (tick),
      .level_i(level),
      .cfg_i  (cfg_q),
      .ev_o   (lane_ev[k])
    );
  end

  mkced_merge #(
    .NUM_KEYS(NUM_KEYS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (tick),
    .lane_ev_i   (lane_ev),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .key_index_o (key_index_o),
    .key_event_o (evt),
    .last_o      (last_o),
    .busy_stall_o(in_stall_o)
  );

  assign key_event_o = evt;

endmodule

// ===== rtl/mkced_checker.sv =====
// ----------------------------------------------------------------------------
// Event detector port checker
// Concurrent checks on the top level ports, attached with a bind.
// ----------------------------------------------------------------------------
module mkced_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] key_index_o,
  input logic [2:0] key_event_o,
  input logic       last_o
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(key_index_o) &&
      $stable(key_event_o) && $stable(last_o))
    else $error("result changed while stalled");

  // Input is only held off while events are pending.
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending event");

  // More events of the same tick follow a non-final event.
  a_tick_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("tick ended without a final event");

  // No new tick is taken while a non-final event is pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("tick accepted while events pending");

endmodule

bind multi_key_click_event_detector_core mkced_checker u_mkced_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .key_index_o(key_index_o),
  .key_event_o(key_event_o),
  .last_o     (last_o)
);
